// File: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define BBSF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define BBSF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/bbsf_pkg.sv
// types and constants of the bounded byte stream fifo
`default_nettype none

package bbsf_pkg;

  localparam int DATA_W  = 8;
  localparam int CFG_W   = 11;
  localparam int OFF_W   = 10;
  localparam int LEVEL_W = 11;
  localparam int TOTAL_W = 48;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(1024);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PEEK  = 2'd2,
    OP_END   = 2'd3
  } op_e;

endpackage

`default_nettype wire

// File: src/bounded_byte_stream_fifo.sv
// top level of the bounded byte stream fifo
`default_nettype none

// bounded byte fifo with an end-of-input mark
//
// command channel: an operation (write, read, peek, end input) is taken at a
// rising edge where start is high and busy is low. busy stays low: one
// operation may be taken every clock cycle, back to back.
// result channel: exactly one result per operation, shown for one cycle with
// done_o high, in the cycle straight after the transfer.
// the receiver cannot stall, so no result is ever held back.
// throughput: 1 operation per cycle, set by the single-port byte store, which
// takes one write or one read per cycle; its read data is registered and
// drives data_out_o in the result cycle.
// a write lands outside the live region (behind the last byte) and reads or
// peeks only touch the live region; a read or peek of the entry written by
// the transfer before it sees the stored byte, so no forwarding is needed.
// configuration channel: cfg_valid_i with cfg_capacity_i, always ready; the
// capacity must only be changed while no result is outstanding.
// reset: pointers, fill level, totals and the ended flag clear, capacity
// returns to 1024; the byte store is not cleared (it is read only where it
// was written).
module bounded_byte_stream_fifo
  import bbsf_pkg::*;
#(
  parameter int MAX_DEPTH = 1024
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // command channel
  input  wire                 start,
  output logic                busy,
  input  wire  [1:0]          op_i,
  input  wire  [DATA_W-1:0]   write_byte_i,
  input  wire  [OFF_W-1:0]    offset_i,
  // result channel
  output logic                done_o,
  output logic                ok_o,
  output logic [DATA_W-1:0]   data_out_o,
  output logic [LEVEL_W-1:0]  fill_level_o,
  output logic [LEVEL_W-1:0]  space_left_o,
  output logic [TOTAL_W-1:0]  total_written_o,
  output logic [TOTAL_W-1:0]  total_read_o,
  output logic                ended_o,
  output logic                at_eof_o,
  // configuration channel
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire  [CFG_W-1:0]    cfg_capacity_i
);

  // address width, count width (holds MAX_DEPTH itself) and a working width
  // wide enough for compares against the capacity and for pointer sums
  localparam int AW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW  = $clog2(MAX_DEPTH + 1);
  localparam int XW  = ((CW > CFG_W) ? CW : CFG_W) + 1;

  localparam logic [XW-1:0] DEPTH_X    = XW'(MAX_DEPTH);
  localparam logic [AW-1:0] LAST_ENTRY = AW'(MAX_DEPTH - 1);

  // control and status state
  logic [CFG_W-1:0]   capacity_q;
  logic [AW-1:0]      head_q,  head_d;
  logic [CW-1:0]      count_q, count_d;
  logic [TOTAL_W-1:0] wr_total_q, wr_total_d;
  logic [TOTAL_W-1:0] rd_total_q, rd_total_d;
  logic               ended_q, ended_d;

  // result registers
  logic               done_q;
  logic               ok_q, ok_d;
  logic               rd_sel_q, rd_sel_d;
  logic [LEVEL_W-1:0] space_q, space_d;

  // byte store
  logic [DATA_W-1:0]  store_q [MAX_DEPTH];
  logic [DATA_W-1:0]  rdata_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;

  // datapath
  op_e                op;
  logic               accept;
  logic [XW-1:0]      cap_x, count_x, offset_x, addend_x, sum_x, wrap_x, count_dx;
  logic               write_ok, read_ok, peek_ok;

  assign op          = op_e'(op_i);
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_comb begin
    // effective capacity: the register clipped to the storage depth
    cap_x    = (XW'(capacity_q) > DEPTH_X) ? DEPTH_X : XW'(capacity_q);
    count_x  = XW'(count_q);
    offset_x = XW'(offset_i);

    write_ok = (op == OP_WRITE) && (count_x < cap_x);
    read_ok  = (op == OP_READ)  && (count_q != '0);
    peek_ok  = (op == OP_PEEK)  && (offset_x < count_x);

    // one adder serves the write position (head + fill) and the peek
    // position (head + offset); both stay below twice the depth when used
    addend_x = (op == OP_WRITE) ? count_x : offset_x;
    sum_x    = XW'(head_q) + addend_x;
    wrap_x   = (sum_x >= DEPTH_X) ? (sum_x - DEPTH_X) : sum_x;

    mem_we    = accept && write_ok;
    mem_re    = accept && (read_ok || peek_ok);
    mem_waddr = wrap_x[AW-1:0];
    mem_raddr = (op == OP_READ) ? head_q : wrap_x[AW-1:0];

    head_d     = head_q;
    count_d    = count_q;
    wr_total_d = wr_total_q;
    rd_total_d = rd_total_q;
    ended_d    = ended_q;

    unique case (op)
      OP_WRITE: begin
        if (write_ok) begin
          count_d    = count_q + CW'(1);
          wr_total_d = (wr_total_q == '1) ? wr_total_q : wr_total_q + TOTAL_W'(1);
        end
      end
      OP_READ: begin
        if (read_ok) begin
          head_d     = (head_q == LAST_ENTRY) ? '0 : head_q + AW'(1);
          count_d    = count_q - CW'(1);
          rd_total_d = (rd_total_q == '1) ? rd_total_q : rd_total_q + TOTAL_W'(1);
        end
      end
      OP_PEEK: begin
      end
      OP_END: begin
        ended_d = 1'b1;
      end
      default: begin
      end
    endcase

    ok_d     = write_ok || read_ok || peek_ok;
    rd_sel_d = read_ok || peek_ok;

    // space after the step, clamped at zero
    count_dx = XW'(count_d);
    space_d  = (cap_x > count_dx) ? LEVEL_W'(cap_x - count_dx) : '0;
  end

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
      head_q     <= '0;
      count_q    <= '0;
      wr_total_q <= '0;
      rd_total_q <= '0;
      ended_q    <= 1'b0;
      done_q     <= 1'b0;
      ok_q       <= 1'b0;
      rd_sel_q   <= 1'b0;
    end else begin
      done_q <= accept;
      if (cfg_valid_i && cfg_ready_o) begin
        capacity_q <= cfg_capacity_i;
      end
      if (accept) begin
        head_q     <= head_d;
        count_q    <= count_d;
        wr_total_q <= wr_total_d;
        rd_total_q <= rd_total_d;
        ended_q    <= ended_d;
        ok_q       <= ok_d;
        rd_sel_q   <= rd_sel_d;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      space_q <= space_d;
    end
  end

  // single-port byte store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= write_byte_i;
    end
    if (mem_re) begin
      rdata_q <= store_q[mem_raddr];
    end
  end

  // result ports: status comes straight from the state, which holds still
  // until the next transfer
  assign done_o          = done_q;
  assign ok_o            = ok_q;
  assign data_out_o      = rd_sel_q ? rdata_q : '0;
  assign fill_level_o    = LEVEL_W'(XW'(count_q));
  assign space_left_o    = space_q;
  assign total_written_o = wr_total_q;
  assign total_read_o    = rd_total_q;
  assign ended_o         = ended_q;
  assign at_eof_o        = ended_q && (count_q == '0);

endmodule

`default_nettype wire

// File: src/bbsf_checker.sv
// port-level checker for the bounded byte stream fifo, with its bind
`default_nettype none

`include "assert_macros.svh"

module bbsf_checker
  import bbsf_pkg::*;
(
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 start,
  input wire                 busy,
  input wire                 done_o,
  input wire                 ok_o,
  input wire [DATA_W-1:0]    data_out_o,
  input wire [TOTAL_W-1:0]   total_written_o,
  input wire                 ended_o,
  input wire                 at_eof_o
);

  `BBSF_ASSERT(a_one_result_per_transfer, clk_i, rst_ni, done_o == $past(start && !busy), "result strobe does not follow a command transfer")
  `BBSF_ASSERT(a_no_data_on_fail, clk_i, rst_ni, (done_o && !ok_o) |-> (data_out_o == '0), "data_out not zero on a failed operation")
  `BBSF_ASSERT(a_eof_needs_end, clk_i, rst_ni, (done_o && at_eof_o) |-> ended_o, "eof reported without end of input")
  `BBSF_ASSERT(a_ended_sticky, clk_i, rst_ni, (done_o && $past(done_o) && $past(ended_o)) |-> ended_o, "ended flag dropped")
  `BBSF_ASSERT(a_written_monotonic, clk_i, rst_ni, (done_o && $past(done_o)) |-> (total_written_o >= $past(total_written_o)), "written total went down")

endmodule

bind bounded_byte_stream_fifo bbsf_checker u_bbsf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .ok_o            (ok_o),
  .data_out_o      (data_out_o),
  .total_written_o (total_written_o),
  .ended_o         (ended_o),
  .at_eof_o        (at_eof_o)
);

`default_nettype wire

// File: verif/bounded_byte_stream_fifo_tb.sv
// self-checking testbench for the bounded byte stream fifo: directed and random operations
module bounded_byte_stream_fifo_tb
  import bbsf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = 1024;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // settle time after the last result, kept as a margin
  localparam int unsigned SETTLE_CYCLES = 4;
  // ring of predicted results waiting for the block's answer
  localparam int unsigned PEND_DEPTH   = 8;

  // one result as the block reports it, in port order
  typedef struct packed {
    logic               ok;
    logic [DATA_W-1:0]  data;
    logic [LEVEL_W-1:0] fill;
    logic [LEVEL_W-1:0] space;
    logic [TOTAL_W-1:0] wr_total;
    logic [TOTAL_W-1:0] rd_total;
    logic               ended;
    logic               eof;
  } fifo_status_t;

  // scoreboard: keeps its own copy of the fifo and the capacity, predicts the
  // status of each accepted operation and checks results in order
  class fifo_scoreboard;
    logic [DATA_W-1:0]  store [DEPTH];
    int unsigned        head;
    int unsigned        count;
    int unsigned        cap;
    logic [TOTAL_W-1:0] wr_total;
    logic [TOTAL_W-1:0] rd_total;
    bit                 ended;
    fifo_status_t       pending [PEND_DEPTH];
    int unsigned        pend_wr;
    int unsigned        pend_rd;
    int unsigned        errors;
    int unsigned        checked;

    function new();
      head     = 0;
      count    = 0;
      cap      = CAP_RESET;
      wr_total = '0;
      rd_total = '0;
      ended    = 1'b0;
      pend_wr  = 0;
      pend_rd  = 0;
      errors   = 0;
      checked  = 0;
    endfunction

    function void set_capacity(logic [CFG_W-1:0] value);
      cap = value;
    endfunction

    // predicted results not yet seen on the ports
    function int unsigned outstanding();
      return pend_wr - pend_rd;
    endfunction

    // totals stick at all ones
    function logic [TOTAL_W-1:0] bump(logic [TOTAL_W-1:0] total);
      return (&total) ? total : total + 1'b1;
    endfunction

    function void note_op(op_e op, logic [DATA_W-1:0] wbyte, logic [OFF_W-1:0] off);
      fifo_status_t s;
      int unsigned  lim;
      s   = '0;
      lim = (cap > DEPTH) ? DEPTH : cap;
      case (op)
        OP_WRITE: begin
          if (count < lim) begin
            store[(head + count) % DEPTH] = wbyte;
            count++;
            wr_total = bump(wr_total);
            s.ok = 1'b1;
          end
        end
        OP_READ: begin
          if (count > 0) begin
            s.data = store[head];
            head   = (head + 1) % DEPTH;
            count--;
            rd_total = bump(rd_total);
            s.ok = 1'b1;
          end
        end
        OP_PEEK: begin
          if (off < count) begin
            s.data = store[(head + off) % DEPTH];
            s.ok   = 1'b1;
          end
        end
        default: ended = 1'b1;
      endcase
      s.fill     = LEVEL_W'(count);
      s.space    = LEVEL_W'((lim > count) ? lim - count : 0);
      s.wr_total = wr_total;
      s.rd_total = rd_total;
      s.ended    = ended;
      s.eof      = ended && (count == 0);
      pending[pend_wr % PEND_DEPTH] = s;
      pend_wr++;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch on result %0d: %s", $realtime, checked, what);
    endtask

    task compare(string name, logic [TOTAL_W-1:0] got, logic [TOTAL_W-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    task check_result(fifo_status_t got);
      fifo_status_t want;
      if (pend_wr == pend_rd) begin
        report_mismatch("result with no operation outstanding");
        return;
      end
      want = pending[pend_rd % PEND_DEPTH];
      pend_rd++;
      compare("ok", got.ok, want.ok);
      compare("data_out", got.data, want.data);
      compare("fill_level", got.fill, want.fill);
      compare("space_left", got.space, want.space);
      compare("total_written", got.wr_total, want.wr_total);
      compare("total_read", got.rd_total, want.rd_total);
      compare("ended", got.ended, want.ended);
      compare("at_eof", got.eof, want.eof);
      checked++;
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         op_i;
  logic [DATA_W-1:0]  write_byte_i;
  logic [OFF_W-1:0]   offset_i;
  logic               done_o;
  logic               ok_o;
  logic [DATA_W-1:0]  data_out_o;
  logic [LEVEL_W-1:0] fill_level_o;
  logic [LEVEL_W-1:0] space_left_o;
  logic [TOTAL_W-1:0] total_written_o;
  logic [TOTAL_W-1:0] total_read_o;
  logic               ended_o;
  logic               at_eof_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CFG_W-1:0]   cfg_capacity_i;

  fifo_scoreboard sb = new();
  int unsigned    cycle_count = 0;

  bounded_byte_stream_fifo #(
    .MAX_DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .write_byte_i   (write_byte_i),
    .offset_i       (offset_i),
    .done_o         (done_o),
    .ok_o           (ok_o),
    .data_out_o     (data_out_o),
    .fill_level_o   (fill_level_o),
    .space_left_o   (space_left_o),
    .total_written_o(total_written_o),
    .total_read_o   (total_read_o),
    .ended_o        (ended_o),
    .at_eof_o       (at_eof_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_capacity_i (cfg_capacity_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result monitor: every strobed cycle is one result, checked at the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result(fifo_status_t'({ok_o, data_out_o, fill_level_o, space_left_o,
                                      total_written_o, total_read_o, ended_o, at_eof_o}));
  end

  // watchdog, far above the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // idle gap before the next operation: mostly none or short, now and then long
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned roll;
    roll = $urandom_range(99);
    if (quiet || roll < 55)
      return 0;
    else if (roll < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  // one command transfer, entered and left at a falling edge; start stays high
  // into the next operation when there is no gap
  task automatic issue(op_e op, logic [DATA_W-1:0] wbyte, logic [OFF_W-1:0] off,
                       int unsigned gap);
    op_i         = op;
    write_byte_i = wbyte;
    offset_i     = off;
    start        = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_op(op, wbyte, off);
    @(negedge clk_i);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // capacity is only changed with nothing in flight
  task automatic write_capacity(logic [CFG_W-1:0] value);
    start = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_capacity_i = value;
    cfg_valid_i    = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_capacity(value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // a run of random operations under one capacity; weights are percentages
  // for write, read and peek, the rest is end input
  task automatic run_phase(logic [CFG_W-1:0] cap, int unsigned n_ops, int unsigned w_pct,
                           int unsigned r_pct, int unsigned p_pct);
    int unsigned      roll;
    bit               quiet;
    op_e              op;
    logic [OFF_W-1:0] off;
    write_capacity(cap);
    quiet = 1'b0;
    for (int unsigned i = 0; i < n_ops; i++) begin
      // some stretches run back to back with no idling at all
      if (i % 50 == 0)
        quiet = ($urandom_range(2) == 0);
      roll = $urandom_range(99);
      if (roll < w_pct)
        op = OP_WRITE;
      else if (roll < w_pct + r_pct)
        op = OP_READ;
      else if (roll < w_pct + r_pct + p_pct)
        op = OP_PEEK;
      else
        op = OP_END;
      // half the peeks land inside the live bytes, the rest anywhere
      if (sb.count > 0 && $urandom_range(1) == 0)
        off = OFF_W'($urandom_range(sb.count - 1));
      else
        off = OFF_W'($urandom_range(DEPTH - 1));
      issue(op, DATA_W'($urandom_range(255)), off, pick_gap(quiet));
    end
  endtask

  initial begin
    start          = 1'b0;
    op_i           = OP_WRITE;
    write_byte_i   = '0;
    offset_i       = '0;
    cfg_valid_i    = 1'b0;
    cfg_capacity_i = '0;
    rst_ni         = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty fifo: read and peek give nothing
    issue(OP_READ, 8'h00, 10'd0, pick_gap(1'b0));
    issue(OP_PEEK, 8'h00, 10'd0, pick_gap(1'b0));
    // byte extremes, then peeks inside, at and far past the fill level
    issue(OP_WRITE, 8'h00, 10'd0, pick_gap(1'b0));
    issue(OP_WRITE, 8'hFF, 10'd0, pick_gap(1'b0));
    issue(OP_WRITE, 8'hA5, 10'd0, pick_gap(1'b0));
    issue(OP_PEEK, 8'h00, 10'd0, pick_gap(1'b0));
    issue(OP_PEEK, 8'h00, 10'd2, pick_gap(1'b0));
    issue(OP_PEEK, 8'h00, 10'd3, pick_gap(1'b0));
    issue(OP_PEEK, 8'h00, 10'd1023, pick_gap(1'b0));
    issue(OP_READ, 8'h00, 10'd0, pick_gap(1'b0));
    // end of input twice, then a write after it is still taken
    issue(OP_END, 8'h00, 10'd0, pick_gap(1'b0));
    issue(OP_END, 8'h00, 10'd0, pick_gap(1'b0));
    issue(OP_WRITE, 8'h5A, 10'd0, pick_gap(1'b0));
    // drain to eof and one read past it
    issue(OP_READ, 8'h00, 10'd0, pick_gap(1'b0));
    issue(OP_READ, 8'h00, 10'd0, pick_gap(1'b0));
    issue(OP_READ, 8'h00, 10'd0, pick_gap(1'b0));
    issue(OP_READ, 8'h00, 10'd0, pick_gap(1'b0));

    // tiny capacity: third write finds the fifo full and is dropped
    write_capacity(11'd2);
    issue(OP_WRITE, 8'h11, 10'd0, pick_gap(1'b0));
    issue(OP_WRITE, 8'h22, 10'd0, pick_gap(1'b0));
    issue(OP_WRITE, 8'h33, 10'd0, pick_gap(1'b0));
    // capacity lowered under the fill level: nothing lost, writes refused
    write_capacity(11'd1);
    issue(OP_WRITE, 8'h44, 10'd0, pick_gap(1'b0));
    issue(OP_PEEK, 8'h00, 10'd1, pick_gap(1'b0));
    issue(OP_READ, 8'h00, 10'd0, pick_gap(1'b0));
    issue(OP_READ, 8'h00, 10'd0, pick_gap(1'b0));
    // zero capacity
    write_capacity(11'd0);
    issue(OP_WRITE, 8'h77, 10'd0, pick_gap(1'b0));
    issue(OP_READ, 8'h00, 10'd0, pick_gap(1'b0));

    // fill past half the store with a capacity above the storage size
    run_phase(11'd2047, 680, 90, 2, 7);
    // capacity well under the fill level, mostly reads until it drains below
    run_phase(11'd300, 680, 10, 82, 8);
    // balanced traffic under the edge capacities and a random one
    run_phase(11'd0, 40, 45, 40, 13);
    run_phase(11'd1, 40, 45, 40, 13);
    run_phase(11'd1023, 40, 45, 40, 13);
    run_phase(11'd1024, 40, 45, 40, 13);
    run_phase(CFG_W'($urandom_range(2, 2047)), 40, 45, 40, 13);

    start = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: bounded_byte_stream_fifo.f
+incdir+src
src/bbsf_pkg.sv
src/bounded_byte_stream_fifo.sv
src/bbsf_checker.sv
verif/bounded_byte_stream_fifo_tb.sv
